[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the RTL; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clk_i, masked while rst_ni is low
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true on a rising clk_i out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[hdl/utff_pkg.sv]
// ----------------------------------------------------------------------------
// utff_pkg
// Shared types and constants of the UDP test frame filter.
// ----------------------------------------------------------------------------
package utff_pkg;

  // Frame position counter
  localparam int unsigned MaxFrameBytes = 16383;
  localparam int unsigned PosW          = $clog2(MaxFrameBytes + 1);
  localparam int unsigned MinTestLen    = 52;

  // Header positions and values
  localparam int unsigned PosTypeHi   = 12;
  localparam int unsigned PosTypeLo   = 13;
  localparam int unsigned PosIpHdrLen = 14;
  localparam int unsigned PosIpProto  = 23;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  IpProtoUdp    = 8'd17;

  // UDP header offset: 14 + 4 * nibble, at most 74
  localparam int unsigned UdpOffW     = 7;
  localparam int unsigned UdpPortHiOf = 2;
  localparam int unsigned UdpPortLoOf = 3;
  localparam int unsigned UdpPayOf    = 8;

  // Payload magic
  localparam int unsigned MagicLen  = 10;
  localparam int unsigned MagicBits = 8 * MagicLen;
  localparam int unsigned MagicIdxW = $clog2(MagicLen);

  // Register reset values
  localparam logic [15:0] DestPortRst = 16'd5678;
  localparam logic [31:0] Magic03Rst  = 32'd1266249571;
  localparam logic [31:0] Magic47Rst  = 32'd1701994837;
  localparam logic [15:0] Magic89Rst  = 16'd17488;

  // Register map, word index
  localparam int unsigned RegIdxW = 2;
  typedef enum logic [RegIdxW-1:0] {
    RegDestPort = 2'd0,
    RegMagic03  = 2'd1,
    RegMagic47  = 2'd2,
    RegMagic89  = 2'd3
  } utff_reg_e;

  // Configuration seen by the checker
  typedef struct packed {
    logic [15:0]          dest_port;
    logic [MagicBits-1:0] magic;     // byte 0 in the top bits
  } utff_cfg_t;

endpackage

[hdl/utff_if.sv]
// ----------------------------------------------------------------------------
// utff_if
// Valid/ready channels: frame bytes in, match results out.
// ----------------------------------------------------------------------------
interface utff_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface utff_out_if;
  logic valid;
  logic ready;
  logic is_match;

  modport source (output valid, output is_match, input ready);
  modport sink   (input valid, input is_match, output ready);
endinterface

[hdl/udp_test_frame_filter.sv]
// ----------------------------------------------------------------------------
// udp_test_frame_filter
// Finds IPv4/UDP test frames in Ethernet, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one frame byte per item, starting at the destination MAC;
//   last_byte marks the final byte. For each last byte one item appears on
//   out_o with is_match set if the frame is at least 52 bytes, IPv4, UDP,
//   carries the configured destination port and the 10 configured magic
//   bytes right after the UDP header. Other bytes produce no result.
//   Throughput: one byte per cycle, limited by the single input stage that
//   feeds the check logic, while no last byte waits on the result register.
//   A last byte passes the input stage, then the result register, to out_o.
//   If out_o stalls, the result register holds; non-last bytes keep flowing,
//   and a following last byte waits in the input stage until the result
//   register drains.
//   Reset clears the frame state and loads the default port and magic.
//   APB registers (word addresses): 0 dest port, 1 magic 0..3, 2 magic 4..7,
//   3 magic 8..9. Write them only while no frame is in flight.
// ----------------------------------------------------------------------------
module udp_test_frame_filter
  import utff_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // frame and result channels
  utff_in_if.sink     in_i,
  utff_out_if.source  out_o,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] dest_port_q;
  logic [31:0] magic03_q;
  logic [31:0] magic47_q;
  logic [15:0] magic89_q;
  utff_reg_e   reg_idx;
  logic        wr_en;
  utff_cfg_t   cfg;

  assign pready  = 1'b1;
  assign reg_idx = utff_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_port_q <= DestPortRst;
      magic03_q   <= Magic03Rst;
      magic47_q   <= Magic47Rst;
      magic89_q   <= Magic89Rst;
    end else if (wr_en) begin
      case (reg_idx)
        RegDestPort: dest_port_q <= pwdata[15:0];
        RegMagic03:  magic03_q   <= pwdata;
        RegMagic47:  magic47_q   <= pwdata;
        RegMagic89:  magic89_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      RegDestPort: prdata = {16'h0, dest_port_q};
      RegMagic03:  prdata = magic03_q;
      RegMagic47:  prdata = magic47_q;
      RegMagic89:  prdata = {16'h0, magic89_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg.dest_port = dest_port_q;
  assign cfg.magic     = {magic03_q, magic47_q, magic89_q};

  utff_check u_check (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

[hdl/utff_check.sv]
// ----------------------------------------------------------------------------
// utff_check
// Per-byte frame checker: input stage, check logic, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utff_check
  import utff_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  utff_cfg_t  cfg_i,
  utff_in_if.sink    in_i,
  utff_out_if.source out_o
);

  // Input stage
  logic       st_valid_q;
  logic [7:0] st_byte_q;
  logic       st_last_q;
  logic       st_adv;

  // Frame state
  logic [PosW-1:0]    pos_q, pos_d;
  logic [7:0]         type_hi_q, type_hi_d;
  logic [UdpOffW-1:0] udp_off_q, udp_off_d;
  logic [7:0]         port_hi_q, port_hi_d;
  logic               pass_q, pass_d;
  logic               seen_q, seen_d;
  logic               match_d;

  // Result register
  logic out_valid_q;
  logic match_q;

  // A non-last item never waits on the result register
  assign st_adv     = st_valid_q && (!st_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !st_valid_q || st_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      st_valid_q <= 1'b1;
    end else if (st_adv) begin
      st_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      st_byte_q <= in_i.frame_byte;
      st_last_q <= in_i.last_byte;
    end
  end

  // Check logic for the byte in the input stage
  always_comb begin
    logic              sat;
    logic [PosW-1:0]   off;
    logic [PosW-1:0]   mag_idx;
    logic [6:0]        mag_msb;
    logic              long_enough;

    pos_d     = pos_q;
    type_hi_d = type_hi_q;
    udp_off_d = udp_off_q;
    port_hi_d = port_hi_q;
    pass_d    = pass_q;
    seen_d    = seen_q;

    sat     = (pos_q >= PosW'(MaxFrameBytes));
    off     = PosW'(udp_off_q);
    mag_idx = pos_q - off - PosW'(UdpPayOf);
    mag_msb = 7'(MagicBits - 1) - {mag_idx[MagicIdxW-1:0], 3'b000};

    if (!sat) begin
      pos_d = pos_q + PosW'(1);
      if (pos_q == PosW'(PosTypeHi)) begin
        type_hi_d = st_byte_q;
      end
      if (pos_q == PosW'(PosTypeLo) && {type_hi_q, st_byte_q} != EtherTypeIpv4) begin
        pass_d = 1'b0;
      end
      if (pos_q == PosW'(PosIpHdrLen)) begin
        udp_off_d = UdpOffW'(PosIpHdrLen) + {1'b0, st_byte_q[3:0], 2'b00};
      end
      if (pos_q == PosW'(PosIpProto) && st_byte_q != IpProtoUdp) begin
        pass_d = 1'b0;
      end
      if (pos_q > PosW'(PosIpHdrLen)) begin
        if (pos_q == off + PosW'(UdpPortHiOf)) begin
          port_hi_d = st_byte_q;
        end
        if (pos_q == off + PosW'(UdpPortLoOf) && {port_hi_q, st_byte_q} != cfg_i.dest_port) begin
          pass_d = 1'b0;
        end
        if (pos_q >= off + PosW'(UdpPayOf) && pos_q < off + PosW'(UdpPayOf + MagicLen)) begin
          if (st_byte_q != cfg_i.magic[mag_msb -: 8]) begin
            pass_d = 1'b0;
          end
          if (pos_q == off + PosW'(UdpPayOf + MagicLen - 1)) begin
            seen_d = 1'b1;
          end
        end
      end
    end

    long_enough = sat || (pos_q + PosW'(1) >= PosW'(MinTestLen));
    match_d     = long_enough && pass_d && seen_d;

    // End of frame: back to the start-of-frame state
    if (st_last_q) begin
      pos_d     = '0;
      type_hi_d = '0;
      udp_off_d = '0;
      port_hi_d = '0;
      pass_d    = 1'b1;
      seen_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      type_hi_q <= '0;
      udp_off_q <= '0;
      port_hi_q <= '0;
      pass_q    <= 1'b1;
      seen_q    <= 1'b0;
    end else if (st_adv) begin
      pos_q     <= pos_d;
      type_hi_q <= type_hi_d;
      udp_off_q <= udp_off_d;
      port_hi_q <= port_hi_d;
      pass_q    <= pass_d;
      seen_q    <= seen_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_adv && st_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_adv && st_last_q) begin
      match_q <= match_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.is_match = match_q;

  // Checks
  `ASSERT_CLK(a_last_gives_result, (st_adv && st_last_q) |=> out_valid_q, "last item lost its result")
  `ASSERT_CLK(a_last_clears_pos, (st_adv && st_last_q) |=> (pos_q == '0), "position not cleared after last item")
  `ASSERT_NEVER(a_pos_range, pos_q > PosW'(MaxFrameBytes), "position beyond saturation")
  `ASSERT_CLK(a_udp_off_form, 1'b1 |-> (udp_off_q == '0 || udp_off_q[1:0] == 2'b10), "bad UDP offset")
  `ASSERT_CLK(a_seen_needs_pos, seen_q |-> (pos_q >= PosW'(PosIpHdrLen + UdpPayOf)), "magic seen too early")

endmodule
